// ----- sv/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// shared constants, field widths and codes of the text console cell writer
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_SPACES  = 4;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/tccw_if.sv -----
// ----------------------------------------------------------------------------
// tccw_if
// valid/ready channels of the text console cell writer
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::CMD_W-1:0]    cmd;
  logic [tccw_pkg::CHAR_W-1:0]   char_code;
  logic [tccw_pkg::RROW_W-1:0]   read_row;
  logic [tccw_pkg::RCOL_W-1:0]   read_col;

  modport source (output valid, cmd, char_code, read_row, read_col, input ready);
  modport sink   (input valid, cmd, char_code, read_row, read_col, output ready);
endinterface

interface tccw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::OCOL_W-1:0]   cursor_col;
  logic [tccw_pkg::OROW_W-1:0]   cursor_row;
  logic [tccw_pkg::CHAR_W-1:0]   cell_char;
  logic [tccw_pkg::ATTR_W-1:0]   cell_attr;
  logic                          scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  output ready);
endinterface

interface tccw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::ATTR_W-1:0]   text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

// ----- sv/text_console_cell_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer
// character cell screen with cursor, scroll, clear and cell read-back
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | cmd, char_code, read_row, read_col
//  out_ch   | out | valid/ready  | cursor_col, cursor_row, cell_char, cell_attr, scrolled
//  cfg_ch   | in  | valid/ready  | text_attribute (always ready)
//
//  plain print, backspace, unused command: EXEC then DONE; read: EXEC, READ, DONE (no READ off screen)
//  tab: EXEC writes TAB_SPACES spaces; newline: FILL blanks the cells left in the row
//  clear: FILL blanks all ROWS*COLS cells; a scroll copies each row up through the cell read port
//  after reset a clearing pass over all ROWS*COLS cells runs before the first item
//  an item is taken while the previous result still waits in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer #(
  parameter int SCREEN_COLS = tccw_pkg::SCREEN_COLS,
  parameter int SCREEN_ROWS = tccw_pkg::SCREEN_ROWS,
  parameter int TAB_SPACES  = tccw_pkg::TAB_SPACES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tccw_in_if.sink    in_ch,
  tccw_out_if.source out_ch,
  tccw_cfg_if.sink   cfg_ch
);

  localparam int TOTAL = SCREEN_ROWS * SCREEN_COLS;
  localparam int LAST  = TOTAL - SCREEN_COLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int IW    = $clog2(TOTAL + 1);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS + 1);
  localparam int TW    = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam int CHW   = tccw_pkg::CHAR_W;
  localparam int ATW   = tccw_pkg::ATTR_W;

  localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);
  localparam logic [AW-1:0] LAST_A = AW'(LAST);
  localparam logic [IW-1:0] LAST_I = IW'(LAST);
  localparam logic [IW-1:0] TOT_I  = IW'(TOTAL);
  localparam logic [IW-1:0] COLS_I = IW'(SCREEN_COLS);
  localparam logic [CW-1:0] CMAX   = CW'(SCREEN_COLS - 1);
  localparam logic [RW-1:0] ROWS_R = RW'(SCREEN_ROWS);
  localparam logic [RW-1:0] RLAST  = RW'(SCREEN_ROWS - 1);
  localparam logic [TW-1:0] TMAX   = TW'(TAB_SPACES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [RW-1:0]                 row_r, row_nxt;
  logic [ATW-1:0]                attr_r, attr_nxt;
  logic [IW-1:0]                 fill_addr_r, fill_addr_nxt;
  logic [IW-1:0]                 fill_end_r, fill_end_nxt;
  logic [2:0]                    fill_ret_r, fill_ret_nxt;
  logic [ATW-1:0]                fill_attr_r, fill_attr_nxt;
  logic [AW-1:0]                 sc_r, sc_nxt;
  logic [TW-1:0]                 tab_cnt_r, tab_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [tccw_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [CHW-1:0]                ch_r, ch_nxt;
  logic [tccw_pkg::RROW_W-1:0]   rrow_r, rrow_nxt;
  logic [tccw_pkg::RCOL_W-1:0]   rcol_r, rcol_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic [CHW-1:0]                res_char_r, res_char_nxt;
  logic [ATW-1:0]                res_attr_r, res_attr_nxt;
  logic                          scr_r, scr_nxt;
  logic [tccw_pkg::OCOL_W-1:0]   out_col_r, out_col_nxt;
  logic [tccw_pkg::OROW_W-1:0]   out_row_r, out_row_nxt;
  logic [CHW-1:0]                out_char_r, out_char_nxt;
  logic [ATW-1:0]                out_attr_r, out_attr_nxt;
  logic                          out_scr_r, out_scr_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (TOTAL)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;
  assign out_ch.scrolled   = out_scr_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    attr_nxt      = attr_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    fill_ret_nxt  = fill_ret_r;
    fill_attr_nxt = fill_attr_r;
    sc_nxt        = sc_r;
    tab_cnt_nxt   = tab_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    rd_ok_nxt     = rd_ok_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    scr_nxt       = scr_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_scr_nxt   = out_scr_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = AW'(rrow_r) * COLS_A + AW'(rcol_r);

    if (cfg_ch.valid) begin
      attr_nxt = cfg_ch.text_attribute;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt      = in_ch.cmd;
          ch_nxt       = in_ch.char_code;
          rrow_nxt     = in_ch.read_row;
          rcol_nxt     = in_ch.read_col;
          rd_ok_nxt    = (32'(in_ch.read_row) < SCREEN_ROWS) &&
                         (32'(in_ch.read_col) < SCREEN_COLS);
          tab_cnt_nxt  = '0;
          scr_nxt      = 1'b0;
          res_char_nxt = '0;
          res_attr_nxt = '0;
          state_nxt    = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r)
          tccw_pkg::CMD_CLEAR: begin
            fill_addr_nxt = '0;
            fill_end_nxt  = TOT_I;
            fill_ret_nxt  = S_DONE;
            fill_attr_nxt = attr_r;
            idx_nxt       = '0;
            col_nxt       = '0;
            row_nxt       = '0;
            state_nxt     = S_FILL;
          end
          tccw_pkg::CMD_READ: begin
            state_nxt = rd_ok_r ? S_READ : S_DONE;
          end
          tccw_pkg::CMD_PRINT: begin
            if (ch_r == tccw_pkg::CH_BACKSPACE) begin
              if (idx_r != '0) begin
                idx_nxt = idx_r - IW'(1);
                if (col_r == '0) begin
                  col_nxt = CMAX;
                  row_nxt = row_r - RW'(1);
                end else begin
                  col_nxt = col_r - CW'(1);
                end
              end
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_nxt);
              ram_wdata = {attr_r, tccw_pkg::CH_NULL};
              state_nxt = S_DONE;
            end else if (row_r == ROWS_R) begin
              scr_nxt   = 1'b1;
              sc_nxt    = '0;
              state_nxt = S_SCROLL;
            end else if (ch_r == tccw_pkg::CH_NEWLINE) begin
              fill_addr_nxt = idx_r;
              fill_end_nxt  = idx_r + COLS_I - IW'(col_r);
              fill_ret_nxt  = S_DONE;
              fill_attr_nxt = attr_r;
              idx_nxt       = idx_r + COLS_I - IW'(col_r);
              col_nxt       = '0;
              row_nxt       = row_r + RW'(1);
              state_nxt     = S_FILL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_r);
              ram_wdata = {attr_r,
                           (ch_r == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : ch_r};
              idx_nxt   = idx_r + IW'(1);
              if (col_r == CMAX) begin
                col_nxt = '0;
                row_nxt = row_r + RW'(1);
              end else begin
                col_nxt = col_r + CW'(1);
              end
              if ((ch_r == tccw_pkg::CH_TAB) && (tab_cnt_r != TMAX)) begin
                tab_cnt_nxt = tab_cnt_r + TW'(1);
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCROLL: begin
        ram_raddr = sc_r + COLS_A;
        if (sc_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = sc_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (sc_r == LAST_A) begin
          fill_addr_nxt = LAST_I;
          fill_end_nxt  = TOT_I;
          fill_ret_nxt  = S_EXEC;
          fill_attr_nxt = attr_r;
          idx_nxt       = LAST_I;
          col_nxt       = '0;
          row_nxt       = RLAST;
          state_nxt     = S_FILL;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(fill_addr_r);
        ram_wdata = {fill_attr_r, tccw_pkg::CH_NULL};
        if (fill_addr_r + IW'(1) == fill_end_r) begin
          state_nxt = fill_ret_r;
        end else begin
          fill_addr_nxt = fill_addr_r + IW'(1);
        end
      end

      S_READ: begin
        res_char_nxt = ram_rdata[CHW-1:0];
        res_attr_nxt = ram_rdata[tccw_pkg::CELL_W-1:CHW];
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = tccw_pkg::OCOL_W'(col_r);
          out_row_nxt   = tccw_pkg::OROW_W'(row_r);
          out_char_nxt  = res_char_r;
          out_attr_nxt  = res_attr_r;
          out_scr_nxt   = scr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tccw_pkg::RESET_ATTR;
      fill_addr_r <= '0;
      fill_end_r  <= TOT_I;
      fill_ret_r  <= S_IDLE;
      fill_attr_r <= tccw_pkg::RESET_ATTR;
      sc_r        <= '0;
      tab_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      scr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_ret_r  <= fill_ret_nxt;
      fill_attr_r <= fill_attr_nxt;
      sc_r        <= sc_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      scr_r       <= scr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // linear cursor and row/column pair stay in step
  a_cursor_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_r) == 32'(row_r) * SCREEN_COLS + 32'(col_r))
    else $error("cursor index and row/column disagree");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < SCREEN_COLS) && (row_r <= ROWS_R) &&
    ((row_r != ROWS_R) || (col_r == '0)))
    else $error("cursor out of range");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && scr_r |-> (row_r >= RLAST))
    else $error("scrolled item left cursor above last row");

  a_scroll_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) && (sc_r == LAST_A) |=>
      (state_r == S_FILL) && (fill_addr_r == LAST_I) && (fill_ret_r == S_EXEC))
    else $error("scroll did not hand over to blanking of last row");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

endmodule

`default_nettype wire

// ----- sv/tccw_ram.sv -----
// ----------------------------------------------------------------------------
// tccw_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
